@@ rtl/wpm_pkg.sv @@
// shared constants, codes and helpers for the wildcard pattern matcher
package wpm_pkg;

    localparam int MAX_PATTERN_DEF = 16;

    localparam int OP_W    = 2;
    localparam int INDEX_W = 4;
    localparam int CHAR_W  = 16;
    localparam int LEN_W   = 5;

    // stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    localparam logic [CHAR_W-1:0] CH_STAR     = 16'h002A;
    localparam logic [CHAR_W-1:0] CH_QUESTION = 16'h003F;
    localparam logic [CHAR_W-1:0] CH_PERIOD   = 16'h002E;
    localparam logic [CHAR_W-1:0] CH_UPPER_A  = 16'h0041;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z  = 16'h005A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 16'h0020;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_CHAR  = 2'd1,
        OP_END   = 2'd2,
        OP_RSVD  = 2'd3
    } op_t;

    // ascii upper case folded to lower case, all other codes unchanged
    function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

@@ rtl/wildcard_pattern_matcher_top.sv @@
// wildcard pattern matcher: pattern store, position set update and result register
//
// Case-insensitive glob matcher for 16-bit characters. A star matches any run
// of characters (also an empty one), a question mark any single character other
// than a period, and every other pattern character matches itself with ASCII
// A-Z folded to a-z. The operation of each input transaction travels on
// s_tuser. Load the pattern with write transactions (one character per index)
// and set cfg_wr_data to its length while the block is idle; then stream the
// subject one character per transaction and close it with an end transaction,
// which returns matched in bit 0 of m_tdata and rearms the matcher for the
// next subject. Trailing stars match an empty remainder and an empty subject
// matches an empty or all-star pattern. One transaction is taken every clock
// cycle while s_tready is high: each one is held in an input register and
// retired by one pass of parallel lane logic, where the star closure of the
// position set is a logarithmic prefix network of clog2(MAX_PATTERN+1) levels.
// A retiring end transaction loads its result into the result register, and
// s_tready drops only while an end transaction waits for a full result
// register that the sink is not draining.
module wildcard_pattern_matcher_top #(
    parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration: pattern length register
    input  logic                           cfg_wr_en,
    input  logic [wpm_pkg::LEN_W-1:0]      cfg_wr_data,
    // input transactions
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [3:0] pattern_index, [19:4] char_code, [23:20] zero
    input  logic [wpm_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] operation
    input  logic [wpm_pkg::OP_W-1:0]       s_tuser,
    // result transactions
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] matched, [7:1] zero
    output logic [wpm_pkg::M_TDATA_W-1:0]  m_tdata
);
    import wpm_pkg::*;

    localparam int NPOS = MAX_PATTERN + 1;
    localparam int LVL  = $clog2(NPOS);

    // configuration register
    logic [LEN_W-1:0]  plen_reg;

    // input register
    logic              in_vld_reg;
    op_t               in_op_reg;
    logic [INDEX_W-1:0] in_idx_reg;
    logic [CHAR_W-1:0] in_char_reg;

    // pattern store, kept pre-decoded per entry
    logic [CHAR_W-1:0] pat_char_reg [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] pat_star_reg;
    logic [MAX_PATTERN-1:0] pat_qm_reg;

    // reachable pattern positions
    logic [NPOS-1:0]   active_reg;
    logic [NPOS-1:0]   active_next;

    // result register
    logic              out_vld_reg;
    logic              out_matched_reg;

    logic              proc;
    logic [CHAR_W-1:0] subj_fold;
    logic [MAX_PATTERN-1:0] lane_on;
    logic [MAX_PATTERN-1:0] prop;
    logic [MAX_PATTERN-1:0] hit;
    logic [MAX_PATTERN-1:0] stay;
    logic [MAX_PATTERN-1:0] adv;
    logic [NPOS-1:0]   end_sel;
    logic [NPOS-1:0]   closed;
    logic [NPOS-1:0]   g_lvl [LVL+1];
    logic [NPOS-1:0]   p_lvl [LVL+1];
    logic [NPOS-1:0]   step_set;
    logic              match_now;

    // the held transaction retires unless it is an end waiting on a busy output
    assign proc     = in_vld_reg &&
                      (in_op_reg != OP_END || !out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || proc;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, out_matched_reg};

    assign subj_fold = fold_case(in_char_reg);

    // per-lane decode of the stored pattern against the current character
    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_lane
        assign lane_on[i] = (i < int'(plen_reg));
        assign prop[i]    = pat_star_reg[i] && lane_on[i];
        assign hit[i]     = pat_qm_reg[i] ? (in_char_reg != CH_PERIOD)
                                          : (pat_char_reg[i] == subj_fold);
        // star lanes hold their position, others step on a hit
        assign stay[i]    = closed[i] && prop[i];
        assign adv[i]     = closed[i] && lane_on[i] && !pat_star_reg[i] && hit[i];
        // end position of the pattern, length saturated to the store depth
        assign end_sel[i] = (int'(plen_reg) == i);
    end
    assign end_sel[MAX_PATTERN] = (int'(plen_reg) >= MAX_PATTERN);

    // star closure as a prefix network: position j is reached from j-1 over a star
    assign g_lvl[0] = active_reg;
    assign p_lvl[0] = {prop, 1'b0};
    for (genvar l = 0; l < LVL; l++)
    begin : g_level
        for (genvar j = 0; j < NPOS; j++)
        begin : g_bit
            if (j >= (1 << l))
            begin : g_comb
                assign g_lvl[l+1][j] = g_lvl[l][j] ||
                                       (p_lvl[l][j] && g_lvl[l][j-(1<<l)]);
                assign p_lvl[l+1][j] = p_lvl[l][j] && p_lvl[l][j-(1<<l)];
            end
            else
            begin : g_pass
                assign g_lvl[l+1][j] = g_lvl[l][j];
                assign p_lvl[l+1][j] = p_lvl[l][j];
            end
        end
    end
    assign closed = g_lvl[LVL];

    // position set after one subject character
    assign step_set  = {1'b0, stay} | {adv, 1'b0};
    assign match_now = |(closed & end_sel);

    always_comb
    begin
        active_next = active_reg;
        if (proc)
        begin
            case (in_op_reg)
                OP_CHAR:  active_next = step_set;
                OP_END:   active_next = NPOS'(1);
                default:  active_next = active_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg    <= '0;
            in_vld_reg  <= 1'b0;
            active_reg  <= NPOS'(1);
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                plen_reg <= cfg_wr_data;
            end
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            active_reg <= active_next;
            if (proc && in_op_reg == OP_END)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= op_t'(s_tuser);
            in_idx_reg  <= s_tdata[INDEX_W-1:0];
            in_char_reg <= s_tdata[INDEX_W +: CHAR_W];
        end
        if (proc && in_op_reg == OP_END)
        begin
            out_matched_reg <= match_now;
        end
    end

    // pattern writes, indexes beyond the store are dropped
    for (genvar e = 0; e < MAX_PATTERN; e++)
    begin : g_store
        always_ff @(posedge clk)
        begin
            if (proc && in_op_reg == OP_WRITE && int'(in_idx_reg) == e)
            begin
                pat_char_reg[e] <= fold_case(in_char_reg);
                pat_star_reg[e] <= (in_char_reg == CH_STAR);
                pat_qm_reg[e]   <= (in_char_reg == CH_QUESTION);
            end
        end
    end

    // an end transaction rearms the position set
    a_end_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && in_op_reg == OP_END) |=> (active_reg == NPOS'(1)))
        else $error("position set not rearmed after end transaction");

    // a new result only comes from a retired end transaction
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(proc && in_op_reg == OP_END))
        else $error("result raised without an end transaction");

    // a stalled input register never takes a new transaction
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !proc) |-> !s_tready)
        else $error("input accepted while held transaction stalled");

    // without a retiring end the position set only changes on a character
    a_set_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(proc && (in_op_reg == OP_CHAR || in_op_reg == OP_END)) |=> $stable(active_reg))
        else $error("position set changed without a subject transaction");

endmodule
